// ===== sv/sst_pkg.sv =====
// Shared types, token kind codes and helpers for the shader source tokenizer.
package sst_pkg;

  localparam int unsigned CountBits = 20;
  localparam int unsigned FieldBits = 20;
  localparam int unsigned TokQDepth = 4;

  typedef logic [CountBits-1:0] cnt_t;
  typedef logic [FieldBits-1:0] field_t;

  typedef enum logic [5:0] {
    K_END, K_ERR, K_COMMENT, K_IDENT, K_NUMBER,
    K_BANG, K_NE, K_PCT, K_PCT_EQ, K_AMP, K_AMP_EQ, K_ANDAND, K_LPAR, K_RPAR,
    K_STAR, K_STAR_EQ, K_PLUS, K_PLUS_EQ, K_INC, K_COMMA, K_DASH, K_DASH_EQ,
    K_DEC, K_DOT, K_SLASH, K_SLASH_EQ, K_COLON, K_SEMI, K_LT, K_LE, K_SHL,
    K_SHL_EQ, K_ASSIGN, K_EQEQ, K_GT, K_GE, K_SHR, K_SHR_EQ, K_QUEST, K_LBRK,
    K_RBRK, K_CARET, K_CARET_EQ, K_XORXOR, K_LBRACE, K_BAR, K_BAR_EQ, K_OROR,
    K_RBRACE, K_TILDE
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e kind;
    field_t    start;
    field_t    length;
    field_t    line;
    logic      last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } tok_push_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ===== sv/sst_scan.sv =====
// Byte input register, scanner state and per-byte token decision logic.
module sst_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              src_valid_i,
  input  logic [7:0]        src_byte_i,
  output logic              src_stall_o,
  input  logic              room_i,
  output sst_pkg::tok_push_t push_o
);
  import sst_pkg::*;

  localparam logic [4:0] M_IDLE   = 5'd0;
  localparam logic [4:0] M_IDENT  = 5'd1;
  localparam logic [4:0] M_NUM    = 5'd2;
  localparam logic [4:0] M_DOTNUM = 5'd3;
  localparam logic [4:0] M_HASH   = 5'd4;
  localparam logic [4:0] M_LCOM   = 5'd5;
  localparam logic [4:0] M_BCOM   = 5'd6;
  localparam logic [4:0] M_BSTAR  = 5'd7;
  localparam logic [4:0] M_BANG   = 5'd8;
  localparam logic [4:0] M_PCT    = 5'd9;
  localparam logic [4:0] M_AMP    = 5'd10;
  localparam logic [4:0] M_STAR   = 5'd11;
  localparam logic [4:0] M_PLUS   = 5'd12;
  localparam logic [4:0] M_DASH   = 5'd13;
  localparam logic [4:0] M_DOT    = 5'd14;
  localparam logic [4:0] M_SLASH  = 5'd15;
  localparam logic [4:0] M_LT     = 5'd16;
  localparam logic [4:0] M_LT2    = 5'd17;
  localparam logic [4:0] M_EQ     = 5'd18;
  localparam logic [4:0] M_GT     = 5'd19;
  localparam logic [4:0] M_GT2    = 5'd20;
  localparam logic [4:0] M_CARET  = 5'd21;
  localparam logic [4:0] M_BAR    = 5'd22;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChLf  = 8'h0A;

  typedef struct packed {
    tok_kind_e  k1;
    logic       has2;
    logic [7:0] c2;
    tok_kind_e  k2;
    tok_kind_e  k0;
  } pair_t;

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic tok_t mk_tok(tok_kind_e k, cnt_t s, cnt_t l, cnt_t ln);
    tok_t t;
    t.kind   = k;
    t.start  = field_t'(s);
    t.length = field_t'(l);
    t.line   = field_t'(ln);
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic pair_t pair_info(logic [4:0] m);
    pair_t p;
    p.k1   = K_ERR;
    p.has2 = 1'b0;
    p.c2   = 8'h00;
    p.k2   = K_ERR;
    p.k0   = K_ERR;
    unique case (m)
      M_BANG:  begin p.k1 = K_NE;       p.k0 = K_BANG;  end
      M_PCT:   begin p.k1 = K_PCT_EQ;   p.k0 = K_PCT;   end
      M_AMP:   begin
        p.k1 = K_AMP_EQ; p.has2 = 1'b1; p.c2 = "&"; p.k2 = K_ANDAND; p.k0 = K_AMP;
      end
      M_STAR:  begin p.k1 = K_STAR_EQ;  p.k0 = K_STAR;  end
      M_PLUS:  begin
        p.k1 = K_PLUS_EQ; p.has2 = 1'b1; p.c2 = "+"; p.k2 = K_INC; p.k0 = K_PLUS;
      end
      M_DASH:  begin
        p.k1 = K_DASH_EQ; p.has2 = 1'b1; p.c2 = "-"; p.k2 = K_DEC; p.k0 = K_DASH;
      end
      M_EQ:    begin p.k1 = K_EQEQ;     p.k0 = K_ASSIGN; end
      M_CARET: begin
        p.k1 = K_CARET_EQ; p.has2 = 1'b1; p.c2 = "^"; p.k2 = K_XORXOR; p.k0 = K_CARET;
      end
      M_BAR:   begin
        p.k1 = K_BAR_EQ; p.has2 = 1'b1; p.c2 = "|"; p.k2 = K_OROR; p.k0 = K_BAR;
      end
      M_LT2:   begin p.k1 = K_SHL_EQ;   p.k0 = K_SHL;   end
      M_GT2:   begin p.k1 = K_SHR_EQ;   p.k0 = K_SHR;   end
      M_SLASH: begin p.k1 = K_SLASH_EQ; p.k0 = K_SLASH; end
      M_LT:    begin p.k1 = K_LE;       p.k0 = K_LT;    end
      M_GT:    begin p.k1 = K_GE;       p.k0 = K_GT;    end
      default: p.k0 = K_ERR;
    endcase
    return p;
  endfunction

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       emit_q;
  logic       proc;

  logic [4:0] mode_q, mode_d;
  cnt_t       ps_q, ps_d, pl_q, pl_d, pline_q, pline_d, lc_q, lc_d, bp_q, bp_d;

  tok_t       tok_v [2];
  logic [1:0] n;
  logic       taken;
  logic       do_pair;
  pair_t      pi;

  assign proc        = in_valid_q && room_i;
  assign src_stall_o = in_valid_q && !room_i;

  always_comb begin
    mode_d   = mode_q;
    ps_d     = ps_q;
    pl_d     = pl_q;
    pline_d  = pline_q;
    lc_d     = lc_q;
    bp_d     = bp_q;
    tok_v[0] = '0;
    tok_v[1] = '0;
    n        = 2'd0;
    taken    = 1'b0;
    do_pair  = 1'b0;
    pi       = pair_info(mode_q);

    unique case (mode_q) inside
      M_IDENT: begin
        if (is_alpha(byte_q) || is_digit(byte_q) || byte_q == "_") begin
          pl_d = sat_inc(pl_d); taken = 1'b1;
        end else begin
          tok_v[n[0]] = mk_tok(K_IDENT, ps_d, pl_d, pline_d); n = n + 2'd1;
          mode_d = M_IDLE;
        end
      end
      M_NUM: begin
        if (is_alpha(byte_q) || is_digit(byte_q) || byte_q == ".") begin
          pl_d = sat_inc(pl_d); taken = 1'b1;
        end else begin
          tok_v[n[0]] = mk_tok(K_NUMBER, ps_d, pl_d, pline_d); n = n + 2'd1;
          mode_d = M_IDLE;
        end
      end
      M_DOTNUM: begin
        if (is_alpha(byte_q) || is_digit(byte_q)) begin
          pl_d = sat_inc(pl_d); taken = 1'b1;
        end else begin
          tok_v[n[0]] = mk_tok(K_NUMBER, ps_d, pl_d, pline_d); n = n + 2'd1;
          mode_d = M_IDLE;
        end
      end
      M_HASH: begin
        if (byte_q == ChLf || byte_q == ChNul) mode_d = M_IDLE;
        else taken = 1'b1;
      end
      M_LCOM: begin
        if (byte_q == ChLf || byte_q == ChNul) begin
          if (emit_q) begin
            tok_v[n[0]] = mk_tok(K_COMMENT, ps_d, pl_d, pline_d); n = n + 2'd1;
          end
          mode_d = M_IDLE;
        end else begin
          pl_d = sat_inc(pl_d); taken = 1'b1;
        end
      end
      M_BCOM, M_BSTAR: begin
        if (byte_q == ChNul) begin
          if (emit_q) begin
            tok_v[n[0]] = mk_tok(K_COMMENT, ps_d, pl_d, pline_d); n = n + 2'd1;
          end
          mode_d = M_IDLE;
        end else begin
          pl_d  = sat_inc(pl_d);
          taken = 1'b1;
          if (mode_q == M_BCOM) begin
            if (byte_q == "*") mode_d = M_BSTAR;
          end else if (byte_q == "/") begin
            if (emit_q) begin
              tok_v[n[0]] = mk_tok(K_COMMENT, ps_d, pl_d, pline_d); n = n + 2'd1;
            end
            mode_d = M_IDLE;
          end else if (byte_q != "*") begin
            mode_d = M_BCOM;
          end
        end
      end
      M_DOT: begin
        if (is_digit(byte_q)) begin
          pl_d = sat_inc(pl_d); taken = 1'b1; mode_d = M_DOTNUM;
        end else begin
          tok_v[n[0]] = mk_tok(K_DOT, ps_d, pl_d, pline_d); n = n + 2'd1;
          mode_d = M_IDLE;
        end
      end
      M_SLASH: begin
        if (byte_q == "/") begin
          pl_d = sat_inc(pl_d); taken = 1'b1; mode_d = M_LCOM;
        end else if (byte_q == "*") begin
          pl_d = sat_inc(pl_d); taken = 1'b1; mode_d = M_BCOM;
        end else begin
          do_pair = 1'b1;
        end
      end
      M_LT: begin
        if (byte_q == "<") begin
          pl_d = sat_inc(pl_d); taken = 1'b1; mode_d = M_LT2;
        end else begin
          do_pair = 1'b1;
        end
      end
      M_GT: begin
        if (byte_q == ">") begin
          pl_d = sat_inc(pl_d); taken = 1'b1; mode_d = M_GT2;
        end else begin
          do_pair = 1'b1;
        end
      end
      M_BANG, M_PCT, M_AMP, M_STAR, M_PLUS, M_DASH, M_EQ, M_CARET, M_BAR,
      M_LT2, M_GT2: do_pair = 1'b1;
      default: mode_d = M_IDLE;
    endcase

    if (do_pair) begin
      if (byte_q == "=") begin
        pl_d = sat_inc(pl_d); taken = 1'b1;
        tok_v[n[0]] = mk_tok(pi.k1, ps_d, pl_d, pline_d); n = n + 2'd1;
      end else if (pi.has2 && byte_q == pi.c2) begin
        pl_d = sat_inc(pl_d); taken = 1'b1;
        tok_v[n[0]] = mk_tok(pi.k2, ps_d, pl_d, pline_d); n = n + 2'd1;
      end else begin
        tok_v[n[0]] = mk_tok(pi.k0, ps_d, pl_d, pline_d); n = n + 2'd1;
      end
      mode_d = M_IDLE;
    end

    if (!taken && byte_q == ChNul) begin
      tok_v[n[0]] = mk_tok(K_END, bp_q, '0, lc_q); n = n + 2'd1;
      ps_d    = bp_q;
      pl_d    = '0;
      pline_d = lc_q;
      mode_d  = M_IDLE;
      lc_d    = '0;
      bp_d    = '0;
    end else begin
      if (!taken) begin
        ps_d    = bp_q;
        pl_d    = cnt_t'(1);
        pline_d = lc_q;
        case (byte_q)
          "#": mode_d = M_HASH;
          "!": mode_d = M_BANG;
          "%": mode_d = M_PCT;
          "&": mode_d = M_AMP;
          "*": mode_d = M_STAR;
          "+": mode_d = M_PLUS;
          "-": mode_d = M_DASH;
          ".": mode_d = M_DOT;
          "/": mode_d = M_SLASH;
          "<": mode_d = M_LT;
          "=": mode_d = M_EQ;
          ">": mode_d = M_GT;
          "^": mode_d = M_CARET;
          "|": mode_d = M_BAR;
          "(": begin tok_v[n[0]] = mk_tok(K_LPAR, ps_d, pl_d, pline_d);   n = n + 2'd1; end
          ")": begin tok_v[n[0]] = mk_tok(K_RPAR, ps_d, pl_d, pline_d);   n = n + 2'd1; end
          ",": begin tok_v[n[0]] = mk_tok(K_COMMA, ps_d, pl_d, pline_d);  n = n + 2'd1; end
          ":": begin tok_v[n[0]] = mk_tok(K_COLON, ps_d, pl_d, pline_d);  n = n + 2'd1; end
          ";": begin tok_v[n[0]] = mk_tok(K_SEMI, ps_d, pl_d, pline_d);   n = n + 2'd1; end
          "?": begin tok_v[n[0]] = mk_tok(K_QUEST, ps_d, pl_d, pline_d);  n = n + 2'd1; end
          "[": begin tok_v[n[0]] = mk_tok(K_LBRK, ps_d, pl_d, pline_d);   n = n + 2'd1; end
          "]": begin tok_v[n[0]] = mk_tok(K_RBRK, ps_d, pl_d, pline_d);   n = n + 2'd1; end
          "{": begin tok_v[n[0]] = mk_tok(K_LBRACE, ps_d, pl_d, pline_d); n = n + 2'd1; end
          "}": begin tok_v[n[0]] = mk_tok(K_RBRACE, ps_d, pl_d, pline_d); n = n + 2'd1; end
          "~": begin tok_v[n[0]] = mk_tok(K_TILDE, ps_d, pl_d, pline_d);  n = n + 2'd1; end
          default: begin
            if (is_alpha(byte_q) || byte_q == "_") begin
              mode_d = M_IDENT;
            end else if (is_digit(byte_q)) begin
              mode_d = M_NUM;
            end else if (!is_space(byte_q)) begin
              tok_v[n[0]] = mk_tok(K_ERR, ps_d, pl_d, pline_d); n = n + 2'd1;
            end
          end
        endcase
      end
      if (byte_q == ChLf) lc_d = sat_inc(lc_q);
      bp_d = sat_inc(bp_q);
    end

    if (n == 2'd1) tok_v[0].last = 1'b1;
    if (n == 2'd2) tok_v[1].last = 1'b1;
  end

  assign push_o.n  = proc ? n : 2'd0;
  assign push_o.t0 = tok_v[0];
  assign push_o.t1 = tok_v[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (src_valid_i && !src_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_valid_i && !src_stall_o) begin
      byte_q <= src_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cfg_we_i) begin
      emit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      ps_q    <= '0;
      pl_q    <= '0;
      pline_q <= '0;
      lc_q    <= '0;
      bp_q    <= '0;
    end else if (proc) begin
      mode_q  <= mode_d;
      ps_q    <= ps_d;
      pl_q    <= pl_d;
      pline_q <= pline_d;
      lc_q    <= lc_d;
      bp_q    <= bp_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && byte_q == ChNul |=> mode_q == M_IDLE && bp_q == '0 && lc_q == '0)
    else $error("end of text did not restart the scanner");

  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && byte_q == ChNul |-> push_o.n != 2'd0 && (push_o.n == 2'd1 ?
      push_o.t0.kind == K_END : push_o.t1.kind == K_END))
    else $error("end of text gave no end beat");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n != 2'd0 |-> room_i)
    else $error("token push without queue room");

  a_push_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n != 2'd3)
    else $error("more than two tokens from one byte");

endmodule

// ===== sv/sst_tok_fifo.sv =====
// Token queue: takes up to two tokens per cycle while it has room, delivers one beat per cycle unless stalled.
module sst_tok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sst_pkg::tok_push_t push_i,
  output logic               room_o,
  output logic               tok_valid_o,
  input  logic               tok_stall_i,
  output sst_pkg::tok_t      head_o
);
  import sst_pkg::*;

  localparam int unsigned PtrW = $clog2(TokQDepth);
  localparam int unsigned CntW = $clog2(TokQDepth + 1);

  tok_t            mem [TokQDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign tok_valid_o = count_q != '0;
  assign pop         = tok_valid_o && !tok_stall_i;
  assign room_o      = count_q <= CntW'(TokQDepth - 2);
  assign head_o      = mem[rd_q];

  assign wr_d    = wr_q + PtrW'(push_i.n);
  assign rd_d    = rd_q + PtrW'(pop);
  assign count_d = count_q + CntW'(push_i.n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wr_q] <= push_i.t0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_q + PtrW'(1)] <= push_i.t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/shader_source_tokenizer_top.sv =====
// A byte accepted into the input register is scanned once the token queue has room; its
// token beats are written into the token queue and offered on the output from its head.
// Throughput: one byte per cycle with queue room; a byte that yields two tokens gives two output
// beats, bounded by the four-entry token queue and its unstalled one-beat-per-cycle drain.
// Reset: asynchronous, clears scanner state, counters, queue pointers and emit_comments;
// no clearing pass is needed.
module shader_source_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        src_valid_i,
  input  logic [7:0]  src_byte_i,
  output logic        src_stall_o,
  output logic        tok_valid_o,
  input  logic        tok_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [19:0] token_start_o,
  output logic [19:0] token_length_o,
  output logic [19:0] token_line_o,
  output logic        last_of_run_o
);
  import sst_pkg::*;

  tok_push_t push;
  tok_t      head;
  logic      room;

  sst_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .src_valid_i(src_valid_i),
    .src_byte_i (src_byte_i),
    .src_stall_o(src_stall_o),
    .room_i     (room),
    .push_o     (push)
  );

  sst_tok_fifo u_tok_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .tok_valid_o(tok_valid_o),
    .tok_stall_i(tok_stall_i),
    .head_o     (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = 20'(head.start);
  assign token_length_o = 20'(head.length);
  assign token_line_o   = 20'(head.line);
  assign last_of_run_o  = head.last;

endmodule
